// ===== rtl/stt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, token kind codes and keyword table for the token scanner.
// No dependencies.
package stt_pkg;

	localparam int POS_BITS_DEF   = 16;
	localparam int KW_MAX_LEN_DEF = 8;

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	// token kinds
	localparam logic [5:0] KIND_LPAREN    = 6'd0;
	localparam logic [5:0] KIND_RPAREN    = 6'd1;
	localparam logic [5:0] KIND_LBRACE    = 6'd2;
	localparam logic [5:0] KIND_RBRACE    = 6'd3;
	localparam logic [5:0] KIND_LBRACKET  = 6'd4;
	localparam logic [5:0] KIND_RBRACKET  = 6'd5;
	localparam logic [5:0] KIND_TRIPLEDOT = 6'd6;
	localparam logic [5:0] KIND_COMMA     = 6'd7;
	localparam logic [5:0] KIND_SEMI      = 6'd8;
	localparam logic [5:0] KIND_PLUS      = 6'd9;
	localparam logic [5:0] KIND_MINUS     = 6'd10;
	localparam logic [5:0] KIND_ARROW     = 6'd11;
	localparam logic [5:0] KIND_STAR      = 6'd12;
	localparam logic [5:0] KIND_SLASH     = 6'd13;
	localparam logic [5:0] KIND_BANG      = 6'd14;
	localparam logic [5:0] KIND_NE        = 6'd15;
	localparam logic [5:0] KIND_ASSIGN    = 6'd16;
	localparam logic [5:0] KIND_FATARROW  = 6'd17;
	localparam logic [5:0] KIND_EQ        = 6'd18;
	localparam logic [5:0] KIND_LT        = 6'd19;
	localparam logic [5:0] KIND_LE        = 6'd20;
	localparam logic [5:0] KIND_GT        = 6'd21;
	localparam logic [5:0] KIND_GE        = 6'd22;
	localparam logic [5:0] KIND_AND       = 6'd23;
	localparam logic [5:0] KIND_OR        = 6'd24;
	localparam logic [5:0] KIND_STRING    = 6'd25;
	localparam logic [5:0] KIND_NUMBER    = 6'd26;
	localparam logic [5:0] KIND_IDENT     = 6'd27;
	localparam logic [5:0] KIND_NULL      = 6'd28;
	localparam logic [5:0] KIND_TRUE      = 6'd29;
	localparam logic [5:0] KIND_FALSE     = 6'd30;
	localparam logic [5:0] KIND_LET       = 6'd31;
	localparam logic [5:0] KIND_IF        = 6'd32;
	localparam logic [5:0] KIND_ELSE      = 6'd33;
	localparam logic [5:0] KIND_WHILE     = 6'd34;
	localparam logic [5:0] KIND_FOR       = 6'd35;
	localparam logic [5:0] KIND_IN        = 6'd36;
	localparam logic [5:0] KIND_BY        = 6'd37;
	localparam logic [5:0] KIND_BREAK     = 6'd38;
	localparam logic [5:0] KIND_CONTINUE  = 6'd39;
	localparam logic [5:0] KIND_EOF       = 6'd40;
	localparam logic [5:0] KIND_ERROR     = 6'd41;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	// keyword text, first character in the low byte, zero padded
	localparam int KW_COUNT = 12;
	localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
		64'("llun"), 64'("eurt"), 64'("eslaf"), 64'("tel"),
		64'("fi"), 64'("esle"), 64'("elihw"), 64'("rof"),
		64'("ni"), 64'("yb"), 64'("kaerb"), 64'("eunitnoc")
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd4, 4'd4, 4'd5, 4'd3, 4'd2, 4'd4, 4'd5, 4'd3, 4'd2, 4'd2, 4'd5, 4'd8
	};
	localparam logic [5:0] KW_KIND [KW_COUNT] = '{
		KIND_NULL, KIND_TRUE, KIND_FALSE, KIND_LET, KIND_IF, KIND_ELSE,
		KIND_WHILE, KIND_FOR, KIND_IN, KIND_BY, KIND_BREAK, KIND_CONTINUE
	};
	localparam logic KW_NEEDS_FOR [KW_COUNT] = '{
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0
	};

	typedef struct packed {
		logic [7:0] source_byte;
		logic       for_context;
	} in_word_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [15:0] token_start;
		logic [15:0] token_length;
		logic        last_of_run;
	} token_t;

	// up to two tokens from one byte, in output order
	typedef struct packed {
		logic [1:0] n_push;
		token_t     t0;
		token_t     t1;
	} push_t;

	typedef struct packed {
		logic [FIFO_CW-1:0] count;
		logic               room2;
	} fifo_stat_t;

endpackage

// ===== rtl/script_token_scanner.sv =====
`timescale 1ns / 1ps
// Streaming token scanner, one source byte per cycle while the result queue has room.
// A taken byte waits in the input register; its tokens are then written into the result queue.
// A byte that ends two tokens pushes both at once; the queue hands them out one at a time.
// The input register waits only while the 4-entry result queue has fewer than two free slots.
// Reset: arst_n clears mode, offsets, word buffer and queue; byte 0 (Eof) also clears the scanner.
// Depends on stt_pkg, stt_lexer_core, stt_token_fifo.
module script_token_scanner #(
	parameter int POS_BITS        = stt_pkg::POS_BITS_DEF,
	parameter int KEYWORD_MAX_LEN = stt_pkg::KW_MAX_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  stt_pkg::in_word_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output stt_pkg::token_t   out_data
);

	logic                valid_s1;
	stt_pkg::in_word_t   word_s1;
	logic                fire_s1;
	stt_pkg::push_t      push;
	stt_pkg::fifo_stat_t fifo_stat;

	assign fire_s1  = valid_s1 && fifo_stat.room2;
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (in_ready) valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) word_s1 <= in_data;
	end

	stt_lexer_core #(
		.POS_BITS        (POS_BITS),
		.KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire_s1),
		.word   (word_s1),
		.push   (push)
	);

	stt_token_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.stat      (fifo_stat)
	);

`ifndef NO_ASSERTIONS
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_stat.count <= stt_pkg::FIFO_CW'(stt_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	a_last_single: assert property (@(posedge clk) disable iff (!arst_n)
		push.n_push == 2'd1 |-> push.t0.last_of_run)
		else $error("single token not marked last");

	a_last_pair: assert property (@(posedge clk) disable iff (!arst_n)
		push.n_push == 2'd2 |-> (push.t1.last_of_run && !push.t0.last_of_run))
		else $error("token pair marked wrong");

	a_eof_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && word_s1.source_byte == stt_pkg::CH_NUL) |-> push.n_push != 2'd0)
		else $error("end of source without token");
`endif

endmodule

// ===== rtl/stt_lexer_core.sv =====
`timescale 1ns / 1ps
// Scanner state registers and the per-byte mode transition / token build.
// Depends on stt_pkg.
module stt_lexer_core #(
	parameter int POS_BITS        = stt_pkg::POS_BITS_DEF,
	parameter int KEYWORD_MAX_LEN = stt_pkg::KW_MAX_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  stt_pkg::in_word_t word,
	output stt_pkg::push_t   push
);

	localparam int CW = $clog2(KEYWORD_MAX_LEN + 2);
	localparam int BW = KEYWORD_MAX_LEN * 8;

	localparam logic [3:0] M_IDLE   = 4'd0;
	localparam logic [3:0] M_MINUS  = 4'd1;
	localparam logic [3:0] M_BANG   = 4'd2;
	localparam logic [3:0] M_EQ     = 4'd3;
	localparam logic [3:0] M_LT     = 4'd4;
	localparam logic [3:0] M_GT     = 4'd5;
	localparam logic [3:0] M_AMP    = 4'd6;
	localparam logic [3:0] M_PIPE   = 4'd7;
	localparam logic [3:0] M_DOT    = 4'd8;
	localparam logic [3:0] M_DOTDOT = 4'd9;
	localparam logic [3:0] M_NUM    = 4'd10;
	localparam logic [3:0] M_IDENT  = 4'd11;
	localparam logic [3:0] M_STR    = 4'd12;

	localparam logic [POS_BITS-1:0] LEN0 = POS_BITS'(0);
	localparam logic [POS_BITS-1:0] LEN1 = POS_BITS'(1);
	localparam logic [POS_BITS-1:0] LEN2 = POS_BITS'(2);
	localparam logic [POS_BITS-1:0] LEN3 = POS_BITS'(3);

	logic [3:0]          mode_q, mode_d;
	logic [POS_BITS-1:0] pos_q, pos_d;
	logic [POS_BITS-1:0] origin_q, origin_d;
	logic [BW-1:0]       wbuf_q, wbuf_d;
	logic [CW-1:0]       wcnt_q, wcnt_d;
	logic                delim_q, delim_d;

	logic [7:0]          c;
	logic [POS_BITS-1:0] span;
	logic                is_digit, is_alpha, is_word, is_space;
	logic [5:0]          word_kind;

	logic                a_v, b_v, used;
	logic [5:0]          a_kind, b_kind;
	logic [POS_BITS-1:0] a_start, a_len, b_start, b_len;
	stt_pkg::token_t     tok_a, tok_b;

	function automatic logic [15:0] to16(input logic [POS_BITS-1:0] v);
		logic [POS_BITS+15:0] e;
		e = {{16{1'b0}}, v};
		return e[15:0];
	endfunction

	assign c        = word.source_byte;
	assign span     = pos_q - origin_q;
	assign is_digit = (c >= "0") && (c <= "9");
	assign is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	assign is_word  = is_alpha || is_digit || (c == "_");
	assign is_space = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));

	// bytes past the word count are zero, so a padded compare is exact
	always_comb begin
		word_kind = stt_pkg::KIND_IDENT;
		for (int i = 0; i < stt_pkg::KW_COUNT; i++) begin
			if ((wcnt_q == CW'(stt_pkg::KW_LEN[i])) && (wbuf_q[63:0] == stt_pkg::KW_TEXT[i])) begin
				if (!stt_pkg::KW_NEEDS_FOR[i] || word.for_context)
					word_kind = stt_pkg::KW_KIND[i];
			end
		end
	end

	always_comb begin
		mode_d   = mode_q;
		origin_d = origin_q;
		wbuf_d   = wbuf_q;
		wcnt_d   = wcnt_q;
		delim_d  = delim_q;
		pos_d    = pos_q + LEN1;
		used     = 1'b0;
		a_v      = 1'b0;
		a_kind   = stt_pkg::KIND_ERROR;
		a_start  = origin_q;
		a_len    = LEN1;
		b_v      = 1'b0;
		b_kind   = stt_pkg::KIND_ERROR;
		b_start  = pos_q;
		b_len    = LEN1;

		// finish or extend the pending token
		case (mode_q)
			M_MINUS: begin
				a_v = 1'b1;
				if (c == ">") begin
					a_kind = stt_pkg::KIND_ARROW; a_len = LEN2; used = 1'b1;
				end else a_kind = stt_pkg::KIND_MINUS;
				mode_d = M_IDLE;
			end
			M_BANG: begin
				a_v = 1'b1;
				if (c == "=") begin
					a_kind = stt_pkg::KIND_NE; a_len = LEN2; used = 1'b1;
				end else a_kind = stt_pkg::KIND_BANG;
				mode_d = M_IDLE;
			end
			M_EQ: begin
				a_v = 1'b1;
				if (c == ">") begin
					a_kind = stt_pkg::KIND_FATARROW; a_len = LEN2; used = 1'b1;
				end else if (c == "=") begin
					a_kind = stt_pkg::KIND_EQ; a_len = LEN2; used = 1'b1;
				end else a_kind = stt_pkg::KIND_ASSIGN;
				mode_d = M_IDLE;
			end
			M_LT: begin
				a_v = 1'b1;
				if (c == "=") begin
					a_kind = stt_pkg::KIND_LE; a_len = LEN2; used = 1'b1;
				end else a_kind = stt_pkg::KIND_LT;
				mode_d = M_IDLE;
			end
			M_GT: begin
				a_v = 1'b1;
				if (c == "=") begin
					a_kind = stt_pkg::KIND_GE; a_len = LEN2; used = 1'b1;
				end else a_kind = stt_pkg::KIND_GT;
				mode_d = M_IDLE;
			end
			M_AMP: begin
				a_v = 1'b1;
				if (c == "&") begin
					a_kind = stt_pkg::KIND_AND; a_len = LEN2; used = 1'b1;
				end
				mode_d = M_IDLE;
			end
			M_PIPE: begin
				a_v = 1'b1;
				if (c == "|") begin
					a_kind = stt_pkg::KIND_OR; a_len = LEN2; used = 1'b1;
				end
				mode_d = M_IDLE;
			end
			M_DOT: begin
				if (is_digit) begin
					mode_d = M_NUM; delim_d = 1'b0; used = 1'b1;
				end else if (c == ".") begin
					mode_d = M_DOTDOT; used = 1'b1;
				end else begin
					a_v = 1'b1; mode_d = M_IDLE;
				end
			end
			M_DOTDOT: begin
				a_v = 1'b1;
				if (c == ".") begin
					a_kind = stt_pkg::KIND_TRIPLEDOT; a_len = LEN3; used = 1'b1;
				end else a_len = LEN2;
				mode_d = M_IDLE;
			end
			M_NUM: begin
				if (is_digit) used = 1'b1;
				else if (!delim_q && ((c == ".") || (c == "x") || (c == "X"))) begin
					delim_d = 1'b1; used = 1'b1;
				end else begin
					a_v = 1'b1; a_kind = stt_pkg::KIND_NUMBER; a_len = span;
					mode_d = M_IDLE;
				end
			end
			M_IDENT: begin
				if (is_word) begin
					used = 1'b1;
					for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
						if (wcnt_q == CW'(i)) wbuf_d[8*i +: 8] = c;
					end
					if (wcnt_q <= CW'(KEYWORD_MAX_LEN)) wcnt_d = wcnt_q + CW'(1);
				end else begin
					a_v = 1'b1; a_kind = word_kind; a_len = span;
					mode_d = M_IDLE;
				end
			end
			M_STR: begin
				if (c == "\"") begin
					a_v = 1'b1; a_kind = stt_pkg::KIND_STRING; a_len = span;
					mode_d = M_IDLE; used = 1'b1;
				end else if ((c == stt_pkg::CH_CR) || (c == stt_pkg::CH_LF) ||
						(c == stt_pkg::CH_NUL)) begin
					a_v = 1'b1; a_len = span;
					mode_d = M_IDLE;
				end else used = 1'b1;
			end
			default: mode_d = M_IDLE;
		endcase

		// byte not consumed above starts something new
		if (!used) begin
			case (c)
				stt_pkg::CH_NUL: begin
					b_v = 1'b1; b_kind = stt_pkg::KIND_EOF; b_len = LEN0;
					mode_d = M_IDLE; pos_d = '0; origin_d = '0;
					wbuf_d = '0; wcnt_d = '0; delim_d = 1'b0;
				end
				"(": begin b_v = 1'b1; b_kind = stt_pkg::KIND_LPAREN; end
				")": begin b_v = 1'b1; b_kind = stt_pkg::KIND_RPAREN; end
				"{": begin b_v = 1'b1; b_kind = stt_pkg::KIND_LBRACE; end
				"}": begin b_v = 1'b1; b_kind = stt_pkg::KIND_RBRACE; end
				"[": begin b_v = 1'b1; b_kind = stt_pkg::KIND_LBRACKET; end
				"]": begin b_v = 1'b1; b_kind = stt_pkg::KIND_RBRACKET; end
				",": begin b_v = 1'b1; b_kind = stt_pkg::KIND_COMMA; end
				";": begin b_v = 1'b1; b_kind = stt_pkg::KIND_SEMI; end
				"+": begin b_v = 1'b1; b_kind = stt_pkg::KIND_PLUS; end
				"*": begin b_v = 1'b1; b_kind = stt_pkg::KIND_STAR; end
				"/": begin b_v = 1'b1; b_kind = stt_pkg::KIND_SLASH; end
				"-": begin mode_d = M_MINUS; origin_d = pos_q; end
				"!": begin mode_d = M_BANG; origin_d = pos_q; end
				"=": begin mode_d = M_EQ; origin_d = pos_q; end
				"<": begin mode_d = M_LT; origin_d = pos_q; end
				">": begin mode_d = M_GT; origin_d = pos_q; end
				"&": begin mode_d = M_AMP; origin_d = pos_q; end
				"|": begin mode_d = M_PIPE; origin_d = pos_q; end
				".": begin mode_d = M_DOT; origin_d = pos_q; end
				"\"": begin mode_d = M_STR; origin_d = pos_q + LEN1; end
				default: begin
					if (is_space) begin
						mode_d = mode_d;
					end else if (is_digit) begin
						mode_d = M_NUM; origin_d = pos_q; delim_d = 1'b0;
					end else if (is_alpha || (c == "_")) begin
						mode_d = M_IDENT; origin_d = pos_q;
						wbuf_d = '0; wbuf_d[7:0] = c; wcnt_d = CW'(1);
					end else b_v = 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		tok_a.token_kind   = a_kind;
		tok_a.token_start  = to16(a_start);
		tok_a.token_length = to16(a_len);
		tok_a.last_of_run  = !b_v;
		tok_b.token_kind   = b_kind;
		tok_b.token_start  = to16(b_start);
		tok_b.token_length = to16(b_len);
		tok_b.last_of_run  = 1'b1;
		push.t1 = tok_b;
		if (a_v) push.t0 = tok_a;
		else push.t0 = tok_b;
		if (!fire) push.n_push = 2'd0;
		else push.n_push = {1'b0, a_v} + {1'b0, b_v};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			pos_q    <= '0;
			origin_q <= '0;
			wbuf_q   <= '0;
			wcnt_q   <= '0;
			delim_q  <= 1'b0;
		end else if (fire) begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			origin_q <= origin_d;
			wbuf_q   <= wbuf_d;
			wcnt_q   <= wcnt_d;
			delim_q  <= delim_d;
		end
	end

endmodule

// ===== rtl/stt_token_fifo.sv =====
`timescale 1ns / 1ps
// Small result queue: takes up to two tokens per cycle, hands out one.
// Depends on stt_pkg.
module stt_token_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  stt_pkg::push_t       push,
	input  logic                 pop_ready,
	output logic                 out_valid,
	output stt_pkg::token_t      out_data,
	output stt_pkg::fifo_stat_t  stat
);

	stt_pkg::token_t                mem_q [stt_pkg::FIFO_DEPTH];
	logic [stt_pkg::FIFO_AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [stt_pkg::FIFO_CW-1:0]    count_q;
	logic                           pop;

	assign out_valid  = (count_q != '0);
	assign out_data   = mem_q[rd_ptr_q];
	assign pop        = out_valid && pop_ready;
	assign stat.count = count_q;
	assign stat.room2 = (count_q <= stt_pkg::FIFO_CW'(stt_pkg::FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n_push != 2'd0) mem_q[wr_ptr_q] <= push.t0;
		if (push.n_push == 2'd2) mem_q[wr_ptr_q + stt_pkg::FIFO_AW'(1)] <= push.t1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + stt_pkg::FIFO_AW'(push.n_push);
			if (pop) rd_ptr_q <= rd_ptr_q + stt_pkg::FIFO_AW'(1);
			count_q <= count_q + stt_pkg::FIFO_CW'(push.n_push) - stt_pkg::FIFO_CW'(pop);
		end
	end

endmodule

// ===== tb/script_token_scanner_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the token scanner: predicts tokens from each accepted source word
// and compares every accepted output word with the oldest predicted token. Depends on stt_pkg.
module script_token_scanner_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  stt_pkg::in_word_t in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  stt_pkg::token_t   out_data,
	output int                mismatches,
	output int                tokens_due
);

	localparam int REPORT_LIMIT = 10;

	typedef enum logic [3:0] {
		SC_IDLE, SC_MINUS, SC_BANG, SC_EQ, SC_LT, SC_GT, SC_AMP, SC_PIPE,
		SC_DOT, SC_DOTDOT, SC_NUM, SC_WORD, SC_STR
	} scan_state_t;

	scan_state_t     scan_state = SC_IDLE;
	logic [15:0]     position   = '0;
	logic [15:0]     origin     = '0;
	logic [63:0]     word_bits  = '0;	// first chars of the word, newest in the low byte
	logic [3:0]      word_cnt   = '0;	// saturates at 9
	logic            delim_seen = 1'b0;
	stt_pkg::token_t step_toks[$];
	stt_pkg::token_t token_due_q[$];
	int              fail_total = 0;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic void emit(input logic [5:0] kind, input logic [15:0] start,
			input logic [15:0] len);
		stt_pkg::token_t t;
		t.token_kind   = kind;
		t.token_start  = start;
		t.token_length = len;
		t.last_of_run  = 1'b0;
		step_toks.push_back(t);
	endfunction

	function automatic void clear_scanner();
		scan_state = SC_IDLE;
		position   = '0;
		origin     = '0;
		word_bits  = '0;
		word_cnt   = '0;
		delim_seen = 1'b0;
	endfunction

	function automatic void word_append(input logic [7:0] c);
		if (word_cnt < 4'd8)
			word_bits = {word_bits[55:0], c};
		if (word_cnt <= 4'd8)
			word_cnt = word_cnt + 4'd1;
	endfunction

	// zero padding plus no NUL in a word means a value match is also a length match
	function automatic logic [5:0] word_kind(input logic ctx);
		if (word_cnt > 4'd8)
			return stt_pkg::KIND_IDENT;
		case (word_bits)
			64'("null"):     return stt_pkg::KIND_NULL;
			64'("true"):     return stt_pkg::KIND_TRUE;
			64'("false"):    return stt_pkg::KIND_FALSE;
			64'("let"):      return stt_pkg::KIND_LET;
			64'("if"):       return stt_pkg::KIND_IF;
			64'("else"):     return stt_pkg::KIND_ELSE;
			64'("while"):    return stt_pkg::KIND_WHILE;
			64'("for"):      return stt_pkg::KIND_FOR;
			64'("in"):       return ctx ? stt_pkg::KIND_IN : stt_pkg::KIND_IDENT;
			64'("by"):       return ctx ? stt_pkg::KIND_BY : stt_pkg::KIND_IDENT;
			64'("break"):    return stt_pkg::KIND_BREAK;
			64'("continue"): return stt_pkg::KIND_CONTINUE;
			default:         return stt_pkg::KIND_IDENT;
		endcase
	endfunction

	task automatic scan_byte(input stt_pkg::in_word_t w);
		logic [7:0]      c;
		logic            ctx;
		logic [15:0]     p;
		logic [15:0]     span;
		logic            used;
		stt_pkg::token_t t;
		c    = w.source_byte;
		ctx  = w.for_context;
		p    = position;
		span = p - origin;
		used = 1'b0;
		step_toks.delete();

		// finish any token waiting on this byte
		case (scan_state)
			SC_MINUS: begin
				if (c == ">") begin emit(stt_pkg::KIND_ARROW, origin, 16'd2); used = 1'b1; end
				else emit(stt_pkg::KIND_MINUS, origin, 16'd1);
				scan_state = SC_IDLE;
			end
			SC_BANG: begin
				if (c == "=") begin emit(stt_pkg::KIND_NE, origin, 16'd2); used = 1'b1; end
				else emit(stt_pkg::KIND_BANG, origin, 16'd1);
				scan_state = SC_IDLE;
			end
			SC_EQ: begin
				if (c == ">") begin
					emit(stt_pkg::KIND_FATARROW, origin, 16'd2); used = 1'b1;
				end else if (c == "=") begin
					emit(stt_pkg::KIND_EQ, origin, 16'd2); used = 1'b1;
				end else emit(stt_pkg::KIND_ASSIGN, origin, 16'd1);
				scan_state = SC_IDLE;
			end
			SC_LT: begin
				if (c == "=") begin emit(stt_pkg::KIND_LE, origin, 16'd2); used = 1'b1; end
				else emit(stt_pkg::KIND_LT, origin, 16'd1);
				scan_state = SC_IDLE;
			end
			SC_GT: begin
				if (c == "=") begin emit(stt_pkg::KIND_GE, origin, 16'd2); used = 1'b1; end
				else emit(stt_pkg::KIND_GT, origin, 16'd1);
				scan_state = SC_IDLE;
			end
			SC_AMP: begin
				if (c == "&") begin emit(stt_pkg::KIND_AND, origin, 16'd2); used = 1'b1; end
				else emit(stt_pkg::KIND_ERROR, origin, 16'd1);
				scan_state = SC_IDLE;
			end
			SC_PIPE: begin
				if (c == "|") begin emit(stt_pkg::KIND_OR, origin, 16'd2); used = 1'b1; end
				else emit(stt_pkg::KIND_ERROR, origin, 16'd1);
				scan_state = SC_IDLE;
			end
			SC_DOT: begin
				if (is_digit(c)) begin
					scan_state = SC_NUM;
					delim_seen = 1'b0;
					used = 1'b1;
				end else if (c == ".") begin
					scan_state = SC_DOTDOT;
					used = 1'b1;
				end else begin
					emit(stt_pkg::KIND_ERROR, origin, 16'd1);
					scan_state = SC_IDLE;
				end
			end
			SC_DOTDOT: begin
				if (c == ".") begin
					emit(stt_pkg::KIND_TRIPLEDOT, origin, 16'd3); used = 1'b1;
				end else emit(stt_pkg::KIND_ERROR, origin, 16'd2);
				scan_state = SC_IDLE;
			end
			SC_NUM: begin
				if (is_digit(c)) begin
					used = 1'b1;
				end else if (!delim_seen && (c == "." || c == "x" || c == "X")) begin
					delim_seen = 1'b1;
					used = 1'b1;
				end else begin
					emit(stt_pkg::KIND_NUMBER, origin, span);
					scan_state = SC_IDLE;
				end
			end
			SC_WORD: begin
				if (is_alpha(c) || is_digit(c) || c == "_") begin
					word_append(c);
					used = 1'b1;
				end else begin
					emit(word_kind(ctx), origin, span);
					scan_state = SC_IDLE;
				end
			end
			SC_STR: begin
				if (c == "\"") begin
					emit(stt_pkg::KIND_STRING, origin, span);
					scan_state = SC_IDLE;
					used = 1'b1;
				end else if (c == stt_pkg::CH_CR || c == stt_pkg::CH_LF ||
						c == stt_pkg::CH_NUL) begin
					emit(stt_pkg::KIND_ERROR, origin, span);
					scan_state = SC_IDLE;
				end else begin
					used = 1'b1;
				end
			end
			default: scan_state = SC_IDLE;
		endcase

		if (!used && c == stt_pkg::CH_NUL) begin
			emit(stt_pkg::KIND_EOF, p, 16'd0);
			clear_scanner();
		end else begin
			if (!used) begin
				case (c)
					"(": emit(stt_pkg::KIND_LPAREN, p, 16'd1);
					")": emit(stt_pkg::KIND_RPAREN, p, 16'd1);
					"{": emit(stt_pkg::KIND_LBRACE, p, 16'd1);
					"}": emit(stt_pkg::KIND_RBRACE, p, 16'd1);
					"[": emit(stt_pkg::KIND_LBRACKET, p, 16'd1);
					"]": emit(stt_pkg::KIND_RBRACKET, p, 16'd1);
					",": emit(stt_pkg::KIND_COMMA, p, 16'd1);
					";": emit(stt_pkg::KIND_SEMI, p, 16'd1);
					"+": emit(stt_pkg::KIND_PLUS, p, 16'd1);
					"*": emit(stt_pkg::KIND_STAR, p, 16'd1);
					"/": emit(stt_pkg::KIND_SLASH, p, 16'd1);
					"-": begin scan_state = SC_MINUS; origin = p; end
					"!": begin scan_state = SC_BANG; origin = p; end
					"=": begin scan_state = SC_EQ; origin = p; end
					"<": begin scan_state = SC_LT; origin = p; end
					">": begin scan_state = SC_GT; origin = p; end
					"&": begin scan_state = SC_AMP; origin = p; end
					"|": begin scan_state = SC_PIPE; origin = p; end
					".": begin scan_state = SC_DOT; origin = p; end
					"\"": begin scan_state = SC_STR; origin = p + 16'd1; end
					default: begin
						if (is_digit(c)) begin
							scan_state = SC_NUM;
							origin = p;
							delim_seen = 1'b0;
						end else if (is_alpha(c) || c == "_") begin
							scan_state = SC_WORD;
							origin = p;
							word_bits = '0;
							word_cnt = '0;
							word_append(c);
						end else if (!is_blank(c)) begin
							emit(stt_pkg::KIND_ERROR, p, 16'd1);
						end
					end
				endcase
			end
			position = p + 16'd1;
		end

		if (step_toks.size() != 0) begin
			t = step_toks.pop_back();
			t.last_of_run = 1'b1;
			step_toks.push_back(t);
		end
		while (step_toks.size() != 0)
			token_due_q.push_back(step_toks.pop_front());
	endtask

	always @(posedge clk) begin : watch
		stt_pkg::token_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				scan_byte(in_data);
			if (out_valid && out_ready) begin
				if (token_due_q.size() == 0) begin
					if (fail_total < REPORT_LIMIT)
						$display("%0t: unexpected token word: kind %0d start %0d length %0d last %0b",
							$time, out_data.token_kind, out_data.token_start,
							out_data.token_length, out_data.last_of_run);
					fail_total++;
				end else begin
					want = token_due_q.pop_front();
					if (out_data.token_kind !== want.token_kind ||
							out_data.token_start !== want.token_start ||
							out_data.token_length !== want.token_length ||
							out_data.last_of_run !== want.last_of_run) begin
						if (fail_total < REPORT_LIMIT)
							$display({"%0t: token mismatch: expected kind %0d start %0d length %0d",
								" last %0b, got kind %0d start %0d length %0d last %0b"},
								$time, want.token_kind, want.token_start, want.token_length,
								want.last_of_run, out_data.token_kind, out_data.token_start,
								out_data.token_length, out_data.last_of_run);
						fail_total++;
					end
				end
			end
		end
		mismatches <= fail_total;
		tokens_due <= token_due_q.size();
	end

endmodule

// ===== tb/script_token_scanner_tb.sv =====
`timescale 1ns / 1ps
// Top of the token scanner testbench: clock, reset, source word stimulus and verdict.
// Depends on stt_pkg, script_token_scanner and script_token_scanner_checker.
module script_token_scanner_tb;

	localparam int RANDOM_ITEMS = 1400;
	localparam int QUIET_ITEMS  = 200;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 10;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	stt_pkg::in_word_t in_data   = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	stt_pkg::token_t   out_data;
	int                mismatches;
	int                tokens_due;

	bit                quiet_tail  = 1'b0;	// no stalls on either side
	int                cycle_count = 0;
	int                fed_bytes   = 0;
	stt_pkg::in_word_t feed_q[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	script_token_scanner DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	script_token_scanner_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.mismatches (mismatches),
		.tokens_due (tokens_due)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("script_token_scanner verification failed");
			$finish;
		end
	end

	initial begin : sink_pacing
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!quiet_tail && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic push_byte(input logic [7:0] c, input logic ctx);
		stt_pkg::in_word_t w;
		w.source_byte = c;
		w.for_context = ctx;
		feed_q.push_back(w);
		fed_bytes++;
	endtask

	task automatic push_text(input string s, input logic ctx);
		int i;
		for (i = 0; i < s.len(); i++)
			push_byte(s[i], ctx);
	endtask

	task automatic send_word(input stt_pkg::in_word_t w);
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic play_feed();
		while (feed_q.size() != 0) begin
			if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			send_word(feed_q.pop_front());
		end
	endtask

	function automatic string op_text(input int unsigned i);
		case (i)
			0:  return "-";
			1:  return "->";
			2:  return "!";
			3:  return "!=";
			4:  return "=";
			5:  return "=>";
			6:  return "==";
			7:  return "<";
			8:  return "<=";
			9:  return ">";
			10: return ">=";
			11: return "&&";
			12: return "||";
			13: return "...";
			14: return "&";
			15: return "|";
			16: return ".";
			default: return "..";
		endcase
	endfunction

	function automatic string kw_text(input int unsigned i);
		case (i)
			0:  return "null";
			1:  return "true";
			2:  return "false";
			3:  return "let";
			4:  return "if";
			5:  return "else";
			6:  return "while";
			7:  return "for";
			8:  return "in";
			9:  return "by";
			10: return "break";
			default: return "continue";
		endcase
	endfunction

	function automatic logic [7:0] word_char(input logic lead);
		int unsigned r;
		r = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
		if (r < 26) return 8'("a" + r);
		if (r < 52) return 8'("A" + r - 26);
		if (r == 52) return "_";
		return 8'("0" + r - 53);
	endfunction

	function automatic logic [7:0] digit_char();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] blank_char();
		int unsigned r;
		r = $urandom_range(8, 13);
		return (r == 8) ? 8'h20 : 8'(r);
	endfunction

	function automatic logic [7:0] text_char();
		logic [7:0] c;
		do c = 8'($urandom_range(1, 255));
		while (c == "\"" || c == stt_pkg::CH_LF || c == stt_pkg::CH_CR);
		return c;
	endfunction

	task automatic add_fragment();
		int unsigned pick;
		int unsigned n;
		int unsigned i;
		logic        ctx;
		string       s;
		ctx  = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 11);
		case (pick)
			0: begin
				s = "(){}[],;+*/";
				push_byte(s[$urandom_range(0, 10)], ctx);
			end
			1, 2: push_text(op_text($urandom_range(0, 17)), ctx);
			3, 4: begin
				if ($urandom_range(0, 3) == 0) begin
					push_byte(".", ctx);
					repeat ($urandom_range(1, 3)) push_byte(digit_char(), ctx);
				end else begin
					repeat ($urandom_range(1, 4)) push_byte(digit_char(), ctx);
					if ($urandom_range(0, 1)) begin
						s = ".xX";
						push_byte(s[$urandom_range(0, 2)], ctx);
					end
					repeat ($urandom_range(0, 3)) push_byte(digit_char(), ctx);
				end
			end
			5, 6: begin
				push_byte(word_char(1'b1), ctx);
				repeat ($urandom_range(0, 11)) push_byte(word_char(1'b0), ctx);
			end
			7: begin
				// keyword, or a near miss one char short or long
				s = kw_text($urandom_range(0, 11));
				n = s.len();
				pick = $urandom_range(0, 3);
				if (pick == 0 && n > 1)
					n = n - 1;
				for (i = 0; i < n; i++)
					push_byte(s[i], ctx);
				if (pick == 3)
					push_byte(word_char(1'b0), ctx);
			end
			8: begin
				push_byte("\"", ctx);
				repeat ($urandom_range(0, 10)) push_byte(text_char(), ctx);
				case ($urandom_range(0, 7))
					0: push_byte(stt_pkg::CH_LF, ctx);
					1: push_byte(stt_pkg::CH_CR, ctx);
					2: push_byte(stt_pkg::CH_NUL, ctx);
					default: push_byte("\"", ctx);
				endcase
			end
			9: push_byte(blank_char(), ctx);
			10: push_byte(8'($urandom_range(1, 255)), ctx);
			default: begin
				if ($urandom_range(0, 2) == 0) begin
					push_byte(stt_pkg::CH_NUL, ctx);
				end else begin
					push_text($urandom_range(0, 1) ? "in" : "by", ctx);
					push_byte($urandom_range(0, 1) ? 8'h20 : ";", 1'($urandom_range(0, 1)));
				end
			end
		endcase
		if ($urandom_range(0, 1))
			push_byte(blank_char(), 1'($urandom_range(0, 1)));
	endtask

	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone & and |, bad dots, leading-dot number, context keywords,
		// high byte, broken strings and end of source inside a string
		push_text("&x|y..;.7 ", 1'b0);
		push_text("in;", 1'b1);
		push_text("by;", 1'b0);
		push_byte(8'hFF, 1'b1);
		push_text("\"a", 1'b0);
		push_byte(stt_pkg::CH_LF, 1'b0);
		push_text("\"b", 1'b1);
		push_byte(stt_pkg::CH_NUL, 1'b0);
		play_feed();

		while (fed_bytes < RANDOM_ITEMS) begin
			if (fed_bytes >= RANDOM_ITEMS - QUIET_ITEMS)
				quiet_tail = 1'b1;
			add_fragment();
			play_feed();
		end

		quiet_tail = 1'b1;
		push_text("\"abcdefghij\" long_identifier_x 12.5e>=", 1'b1);
		push_byte(stt_pkg::CH_NUL, 1'b0);
		play_feed();
		in_valid <= 1'b0;

		do @(posedge clk); while (tokens_due != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && tokens_due == 0)
			$display("script_token_scanner verification clean");
		else
			$display("script_token_scanner verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/stt_pkg.sv
rtl/stt_lexer_core.sv
rtl/stt_token_fifo.sv
rtl/script_token_scanner.sv
tb/script_token_scanner_checker.sv
tb/script_token_scanner_tb.sv
